FILE: hw/rtl/ssetab_pkg.sv
// Shared constants, widths and codes for the sparse set table.
`default_nettype none

package ssetab_pkg;

	localparam int ENTITY_COUNT = 256;
	localparam int DATA_WIDTH   = 32;

	localparam int ENT_W = $clog2(ENTITY_COUNT);
	localparam int CNT_W = ENT_W + 1;
	localparam int DEN_W = ENT_W + DATA_WIDTH;

	localparam int OP_W     = 2;
	localparam int ID_W     = 8;
	localparam int PAY_W    = 32;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssetab_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ssetab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sparse_set_table.sv
// Sparse set table: entity map RAM, dense slot RAM and the operation sequencer.
//
//   channel | handshake       | words
//   --------+-----------------+---------------------------------------------
//   command | start / busy    | op, entity, payload_in
//   result  | done (strobe)   | found, payload_out, slot_out, status, count_out
//
// An add of a new entity, a remove, and any miss finish in READ1; an add of a
// present entity and a lookup hit go on to READ2, since the slot read
// from the entity map RAM addresses the dense RAM in a second read.
// Busy is high from the cycle after accept until the result is registered.
// Reset clears the presence bits and the count at once; no clearing pass.
// The receiver cannot stall: done is high for one cycle per command.
`default_nettype none

module sparse_set_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [ssetab_pkg::OP_W-1:0]   op,
	input  wire logic [ssetab_pkg::ID_W-1:0]   entity,
	input  wire logic [ssetab_pkg::PAY_W-1:0]  payload_in,
	output logic                               done,
	output logic                               found,
	output logic [ssetab_pkg::PAY_W-1:0]       payload_out,
	output logic [ssetab_pkg::SLOT_W-1:0]      slot_out,
	output logic [ssetab_pkg::STATUS_W-1:0]    status,
	output logic [ssetab_pkg::COUNT_W-1:0]     count_out
);

	import ssetab_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		READ1,
		READ2
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [ID_W-1:0]         entity_q;
	logic [DATA_WIDTH-1:0]   pay_q;
	logic [ENT_W-1:0]        slot_q;
	logic [CNT_W-1:0]        count_q;
	logic [ENTITY_COUNT-1:0] present_q;

	logic                    done_q;
	logic                    found_q;
	logic [DATA_WIDTH-1:0]   payload_q;
	logic [ENT_W-1:0]        slot_out_q;
	status_t                 status_q;

	logic                    ent_we;
	logic [ENT_W-1:0]        ent_waddr;
	logic [ENT_W-1:0]        ent_wdata;
	logic [ENT_W-1:0]        ent_raddr;
	logic [ENT_W-1:0]        ent_rdata;

	logic                    den_we;
	logic [ENT_W-1:0]        den_waddr;
	logic [DEN_W-1:0]        den_wdata;
	logic [ENT_W-1:0]        den_raddr;
	logic [DEN_W-1:0]        den_rdata;

	logic                    ent_ok;
	logic [ENT_W-1:0]        eidx;
	logic                    hit;
	logic [ENT_W-1:0]        last_idx;
	logic [ENT_W-1:0]        last_owner;
	logic [DATA_WIDTH-1:0]   den_pay;

	logic                    fin;
	logic                    go_read2;
	logic                    set_present;
	logic                    clr_present;
	logic                    cnt_inc;
	logic                    cnt_dec;
	logic                    r_found;
	logic [DATA_WIDTH-1:0]   r_payload;
	logic [ENT_W-1:0]        r_slot;
	status_t                 r_status;

	ssetab_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTITY_COUNT)
	) u_ent_map (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	ssetab_ram #(
		.WIDTH(DEN_W),
		.DEPTH(ENTITY_COUNT)
	) u_dense (
		.clk   (clk),
		.we    (den_we),
		.waddr (den_waddr),
		.wdata (den_wdata),
		.raddr (den_raddr),
		.rdata (den_rdata)
	);

	assign ent_ok     = (32'(entity_q) < ENTITY_COUNT);
	assign eidx       = ENT_W'(entity_q);
	assign hit        = ent_ok && present_q[eidx];
	assign last_idx   = ENT_W'(count_q - CNT_W'(1));
	assign last_owner = den_rdata[DEN_W-1 -: ENT_W];
	assign den_pay    = den_rdata[DATA_WIDTH-1:0];

	assign ent_raddr = ENT_W'(entity);
	assign den_raddr = (state_q == IDLE) ? last_idx : ent_rdata;

	always_comb begin
		fin         = 1'b0;
		go_read2    = 1'b0;
		set_present = 1'b0;
		clr_present = 1'b0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		r_found     = 1'b0;
		r_payload   = '0;
		r_slot      = '0;
		r_status    = ST_DONE;
		ent_we      = 1'b0;
		ent_waddr   = eidx;
		ent_wdata   = ENT_W'(count_q);
		den_we      = 1'b0;
		den_waddr   = ENT_W'(count_q);
		den_wdata   = {eidx, pay_q};
		case (state_q)
			READ1: begin
				fin = 1'b1;
				if (!ent_ok) begin
					r_status = ST_ABSENT;
				end else begin
					case (op_q)
						OP_ADD: begin
							if (hit) begin
								fin      = 1'b0;
								go_read2 = 1'b1;
							end else if (32'(count_q) >= ENTITY_COUNT) begin
								r_status = ST_FULL;
							end else begin
								ent_we      = 1'b1;
								den_we      = 1'b1;
								set_present = 1'b1;
								cnt_inc     = 1'b1;
								r_payload   = pay_q;
								r_slot      = ENT_W'(count_q);
							end
						end
						OP_REMOVE: begin
							if (!hit || count_q == '0) begin
								r_status = ST_ABSENT;
							end else begin
								if (last_owner != eidx) begin
									ent_we    = 1'b1;
									ent_waddr = last_owner;
									ent_wdata = ent_rdata;
									den_we    = 1'b1;
									den_waddr = ent_rdata;
									den_wdata = den_rdata;
								end
								clr_present = 1'b1;
								cnt_dec     = 1'b1;
								r_found     = 1'b1;
							end
						end
						default: begin
							if (hit) begin
								fin      = 1'b0;
								go_read2 = 1'b1;
							end else begin
								r_status = ST_ABSENT;
							end
						end
					endcase
				end
			end
			READ2: begin
				fin       = 1'b1;
				r_found   = 1'b1;
				r_payload = den_pay;
				r_slot    = slot_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			op_q       <= OP_ADD;
			entity_q   <= '0;
			pay_q      <= '0;
			slot_q     <= '0;
			count_q    <= '0;
			present_q  <= '0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			payload_q  <= '0;
			slot_out_q <= '0;
			status_q   <= ST_DONE;
		end else begin
			done_q <= fin;
			if (fin) begin
				found_q    <= r_found;
				payload_q  <= r_payload;
				slot_out_q <= r_slot;
				status_q   <= r_status;
			end
			if (set_present) begin
				present_q[eidx] <= 1'b1;
			end
			if (clr_present) begin
				present_q[eidx] <= 1'b0;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			case (state_q)
				IDLE: begin
					if (start) begin
						op_q     <= op_t'(op);
						entity_q <= entity;
						pay_q    <= DATA_WIDTH'(payload_in);
						state_q  <= READ1;
					end
				end
				READ1: begin
					slot_q  <= ent_rdata;
					state_q <= go_read2 ? READ2 : IDLE;
				end
				READ2: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign payload_out = PAY_W'(payload_q);
	assign slot_out    = SLOT_W'(slot_out_q);
	assign status      = status_q;
	assign count_out   = COUNT_W'(count_q);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the sparse set table: directed, fill-and-drain and random command tests.
module tb_top;

	import ssetab_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int TABLE_SIZE   = 256;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic                found;
		logic [PAY_W-1:0]    payload;
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} table_result_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic [OP_W-1:0]     op         = OP_ADD;
	logic [ID_W-1:0]     entity     = '0;
	logic [PAY_W-1:0]    payload_in = '0;
	logic                busy;
	logic                done;
	logic                found;
	logic [PAY_W-1:0]    payload_out;
	logic [SLOT_W-1:0]   slot_out;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count_out;

	bit               held[TABLE_SIZE];
	logic [7:0]       slot_of[TABLE_SIZE];
	logic [7:0]       owner_of[TABLE_SIZE];
	logic [PAY_W-1:0] stored_payload[TABLE_SIZE];
	int               used_slots = 0;

	table_result_t expected_results[$];
	int            idle_pct     = 0;
	int            stall_cycles = 0;
	bit            failed       = 1'b0;

	always #6 clk = ~clk;

	sparse_set_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.entity      (entity),
		.payload_in  (payload_in),
		.done        (done),
		.found       (found),
		.payload_out (payload_out),
		.slot_out    (slot_out),
		.status      (status),
		.count_out   (count_out)
	);

	function automatic table_result_t apply_table_op(input logic [OP_W-1:0] opc,
			input logic [ID_W-1:0] ent, input logic [PAY_W-1:0] pay);
		table_result_t r;
		int s;
		int last;
		int last_owner;
		r.found   = 1'b0;
		r.payload = '0;
		r.slot    = '0;
		r.status  = ST_DONE;
		case (opc)
			OP_ADD: begin
				if (held[ent]) begin
					s = slot_of[ent];
					r.found   = 1'b1;
					r.payload = stored_payload[s];
					r.slot    = s[7:0];
				end else if (used_slots >= TABLE_SIZE) begin
					r.status = ST_FULL;
				end else begin
					s = used_slots;
					used_slots++;
					stored_payload[s] = pay;
					slot_of[ent]      = s[7:0];
					owner_of[s]       = ent;
					held[ent]         = 1'b1;
					r.payload = pay;
					r.slot    = s[7:0];
				end
			end
			OP_REMOVE: begin
				if (!held[ent] || used_slots == 0) begin
					r.status = ST_ABSENT;
				end else begin
					s          = slot_of[ent];
					last       = used_slots - 1;
					last_owner = owner_of[last];
					// move the last slot into the freed one
					if (last_owner != ent) begin
						stored_payload[s]    = stored_payload[last];
						slot_of[last_owner]  = s[7:0];
						owner_of[s]          = last_owner[7:0];
					end
					held[ent] = 1'b0;
					used_slots--;
					r.found = 1'b1;
				end
			end
			default: begin
				if (!held[ent]) begin
					r.status = ST_ABSENT;
				end else begin
					s = slot_of[ent];
					r.found   = 1'b1;
					r.payload = stored_payload[s];
					r.slot    = s[7:0];
				end
			end
		endcase
		r.count = used_slots[COUNT_W-1:0];
		return r;
	endfunction

	function automatic logic [ID_W-1:0] pick_held_entity();
		if (used_slots == 0)
			return ID_W'($urandom);
		return owner_of[$urandom_range(0, used_slots - 1)];
	endfunction

	task automatic send_word(input logic [OP_W-1:0] opc, input logic [ID_W-1:0] ent,
			input logic [PAY_W-1:0] pay);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		op         <= opc;
		entity     <= ent;
		payload_in <= pay;
		do @(posedge clk); while (busy);
		expected_results.push_back(apply_table_op(opc, ent, pay));
	endtask

	task automatic test_directed();
		idle_pct = 34;
		send_word(OP_REMOVE, 8'd0, 32'h0);
		send_word(OP_LOOKUP, 8'd0, 32'h0);
		send_word(OP_ADD, 8'd0, 32'h0000_0000);
		send_word(OP_ADD, 8'd255, 32'hFFFF_FFFF);
		send_word(OP_ADD, 8'd0, 32'h1234_5678);
		send_word(OP_LOOKUP, 8'd0, 32'h0);
		send_word(OP_LOOKUP, 8'd255, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 8'd7, 32'h0);
		send_word(OP_SPARE, 8'd255, 32'h0);
		send_word(OP_SPARE, 8'd7, 32'h0);
		send_word(OP_REMOVE, 8'd7, 32'h0);
		send_word(OP_ADD, 8'd128, 32'hA5A5_A5A5);
		send_word(OP_ADD, 8'd1, 32'h5A5A_5A5A);
		send_word(OP_REMOVE, 8'd1, 32'h0);
		send_word(OP_REMOVE, 8'd0, 32'h0);
		send_word(OP_LOOKUP, 8'd128, 32'h0);
		send_word(OP_LOOKUP, 8'd0, 32'h0);
		send_word(OP_ADD, 8'd85, 32'h8000_0001);
		send_word(OP_REMOVE, 8'd255, 32'h0);
		send_word(OP_LOOKUP, 8'd85, 32'h0);
		send_word(OP_REMOVE, 8'd85, 32'h0);
		send_word(OP_REMOVE, 8'd128, 32'h0);
		send_word(OP_REMOVE, 8'd128, 32'h0);
		send_word(OP_LOOKUP, 8'd170, 32'h0);
	endtask

	task automatic test_fill_drain();
		int order[TABLE_SIZE];
		int j;
		int tmp;
		idle_pct = 46;
		while (used_slots > 0)
			send_word(OP_REMOVE, pick_held_entity(), $urandom);
		for (int i = 0; i < TABLE_SIZE; i++)
			order[i] = i;
		for (int i = TABLE_SIZE - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < TABLE_SIZE; i++)
			send_word(OP_ADD, order[i][7:0], $urandom);
		send_word(OP_ADD, order[0][7:0], $urandom);
		send_word(OP_LOOKUP, order[TABLE_SIZE-1][7:0], $urandom);
		send_word(OP_SPARE, ID_W'($urandom), $urandom);
		while (used_slots > 0)
			send_word(OP_REMOVE, pick_held_entity(), $urandom);
		send_word(OP_REMOVE, ID_W'($urandom), $urandom);
	endtask

	task automatic test_random(input int n, input int pct);
		int roll;
		logic [OP_W-1:0] opc;
		logic [ID_W-1:0] ent;
		idle_pct = pct;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				opc = OP_ADD;
			else if (roll < 75)
				opc = OP_REMOVE;
			else if (roll < 95)
				opc = OP_LOOKUP;
			else
				opc = OP_SPARE;
			if (opc != OP_ADD && $urandom_range(0, 99) < 70)
				ent = pick_held_entity();
			else
				ent = ID_W'($urandom);
			send_word(opc, ent, $urandom);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : result_check
		table_result_t exp_r;
		if (done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result word with no command pending");
				failed = 1'b1;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("found", 32'(exp_r.found), 32'(found));
				check_field("payload_out", exp_r.payload, payload_out);
				check_field("slot_out", 32'(exp_r.slot), 32'(slot_out));
				check_field("status", 32'(exp_r.status), 32'(status));
				check_field("count_out", 32'(exp_r.count), 32'(count_out));
			end
		end
		if ((start && busy === 1'b0 && arst_n) || done === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 34);
		test_fill_drain();
		test_random(140, 46);
		test_random(140, 0);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failed)
			$display("Test completed with failures");
		else
			$display("Test completed successfully");
		$finish;
	end

endmodule
